>>> rtl/sr_pkg.sv
// Shared types, widths, register codes and arithmetic helpers for the synaptic rectifier.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package sr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_EXP   = 4;

  localparam int SW  = 32;               // sample
  localparam int AW  = 48;               // addend and result
  localparam int GW  = 40;               // gmax, also the number of division cells
  localparam int EW  = 32;               // eta
  localparam int DW  = 32;               // magnitude of sample minus threshold
  localparam int LW  = 32;               // magnitude of gain
  localparam int PW  = DW * MAX_EXP;     // |d|^p
  localparam int NW  = PW + LW;          // |gain| * |d|^p
  localparam int CW  = 2 * EW + GW;      // eta coefficient times gmax
  localparam int BW_N = NW + 2 * EW;
  localparam int BW_D = CW + EW + FRAC_BITS * MAX_EXP;
  localparam int BW  = ((BW_N > BW_D) ? BW_N : BW_D) + 1;
  localparam int PEW = $clog2(MAX_EXP + 1);
  localparam int SHW = $clog2(FRAC_BITS * MAX_EXP + 1);

  localparam int CIW = 3;                // config index
  localparam int CDW = 40;               // config data

  // accept edge to the edge at which the result transfers
  localparam int LATENCY = GW + MAX_EXP + 4;

  localparam logic [1:0] MODE_BYPASS    = 2'd0;
  localparam logic [1:0] MODE_LINEAR    = 2'd1;
  localparam logic [1:0] MODE_NONLINEAR = 2'd2;

  localparam logic [CIW-1:0] REG_MODE  = 3'd0;
  localparam logic [CIW-1:0] REG_GAIN  = 3'd1;
  localparam logic [CIW-1:0] REG_GMAX  = 3'd2;
  localparam logic [CIW-1:0] REG_ETA   = 3'd3;
  localparam logic [CIW-1:0] REG_THR   = 3'd4;
  localparam logic [CIW-1:0] REG_EXP   = 3'd5;

  localparam logic [1:0]    MODE_RESET = MODE_BYPASS;
  localparam logic [31:0]   GAIN_RESET = 32'(64'd1 << FRAC_BITS);
  localparam logic [GW-1:0] GMAX_RESET = GW'(64'd50000 << FRAC_BITS);
  localparam logic [2:0]    EXP_RESET  = 3'd1;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [31:0]   gain;
    logic [GW-1:0]        gmax;
    logic [EW-1:0]        eta;
    logic signed [31:0]   thr;
    logic [2:0]           expo;
  } cfg_t;

  // after the first stage, through the power stages
  typedef struct packed {
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] talt;
    logic                 nl;
    logic                 gz;
    logic                 dneg;
    logic                 lneg;
    logic [DW-1:0]        dm;
    logic [LW-1:0]        lm;
    logic [PW-1:0]        pw;
    logic [2*EW-1:0]      eu;
    logic [2*EW-1:0]      ee;
    logic [CW-1:0]        ug;
    logic [CW-1:0]        eg;
  } pw_t;

  // after the product with the gain
  typedef struct packed {
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] talt;
    logic                 nl;
    logic                 gz;
    logic                 wpos;
    logic [NW-1:0]        n;
    logic [CW-1:0]        eug;
    logic [CW-1:0]        eeg;
    logic [CW-1:0]        ug;
    logic [CW-1:0]        eg;
  } nm_t;

  // one division step's state, handed from cell to cell
  typedef struct packed {
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] talt;
    logic                 nl;
    logic                 gz;
    logic [BW-1:0]        a;
    logic [BW-1:0]        b;
    logic [BW-1:0]        r;
    logic [GW-1:0]        q;
    logic [GW-1:0]        gsh;
  } stg_t;

  // wide operand times 32 bits, as independent 32x32 partial products
  function automatic logic [NW+31:0] mul_w32(input logic [NW-1:0] x, input logic [31:0] y);
    logic [NW+31:0] acc;
    logic [63:0]    pp;
    acc = '0;
    for (int i = 0; i < NW / 32; i++) begin
      pp  = 64'(x[32*i +: 32]) * 64'(y);
      acc = acc + ((NW+32)'(pp) << (32 * i));
    end
    return acc;
  endfunction

  // wide operand times gmax, split into a low and a high lane
  function automatic logic [NW+GW-1:0] mul_wg(input logic [NW-1:0] x, input logic [GW-1:0] g);
    logic [NW+GW-1:0] lo;
    logic [NW+GW-1:0] hi;
    lo = (NW+GW)'(mul_w32(x, g[31:0]));
    hi = (NW+GW)'(mul_w32(x, 32'(g[GW-1:32]))) << 32;
    return lo + hi;
  endfunction

  function automatic logic [PEW-1:0] clamp_exp(input logic [2:0] e);
    logic [PEW-1:0] p;
    if (e == 3'd0)
      p = PEW'(1);
    else if (32'(e) > MAX_EXP)
      p = PEW'(MAX_EXP);
    else
      p = PEW'(e);
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sr_front.sv
// Front end of the synaptic rectifier: input register, distance, power chain, gain product
// and the forming of the dividend and divisor for the cell chain. Uses sr_pkg.
`default_nettype none
module sr_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic signed [sr_pkg::SW-1:0] in_sample,
  input  wire logic signed [sr_pkg::AW-1:0] in_addend,
  input  var  sr_pkg::cfg_t               cfg,
  output logic                            valid_o,
  output sr_pkg::stg_t                    item_o
);

  logic                          v0_r;
  logic signed [sr_pkg::SW-1:0]  s0_r;
  logic signed [sr_pkg::AW-1:0]  a0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s0_r <= in_sample;
      a0_r <= in_addend;
    end
  end

  // first stage: distance, magnitudes, linear product, eta coefficients
  logic signed [32:0]            dd;
  logic signed [63:0]            prod;
  logic [sr_pkg::EW-1:0]         u;
  sr_pkg::pw_t                   p1_nxt;

  always_comb begin
    dd   = 33'(s0_r) - 33'(cfg.thr);
    prod = 64'(cfg.gain) * 64'(s0_r);
    u    = ~cfg.eta + sr_pkg::EW'(1);
    p1_nxt.addend = a0_r;
    case (cfg.mode)
      sr_pkg::MODE_LINEAR:    p1_nxt.talt = sr_pkg::AW'(prod >>> sr_pkg::FRAC_BITS);
      sr_pkg::MODE_NONLINEAR: p1_nxt.talt = '0;
      default:                p1_nxt.talt = sr_pkg::AW'(s0_r);
    endcase
    p1_nxt.nl   = (cfg.mode == sr_pkg::MODE_NONLINEAR);
    p1_nxt.gz   = (cfg.gmax == '0);
    p1_nxt.dneg = dd[32];
    p1_nxt.lneg = cfg.gain[31];
    p1_nxt.dm   = dd[32] ? sr_pkg::DW'(-dd) : sr_pkg::DW'(dd);
    p1_nxt.lm   = cfg.gain[31] ? sr_pkg::LW'(-33'(cfg.gain)) : sr_pkg::LW'(cfg.gain);
    p1_nxt.pw   = sr_pkg::PW'(p1_nxt.dm);
    p1_nxt.eu   = 64'(cfg.eta) * 64'(u);
    p1_nxt.ee   = 64'(cfg.eta) * 64'(cfg.eta);
    p1_nxt.ug   = sr_pkg::CW'(sr_pkg::mul_w32(sr_pkg::NW'(cfg.gmax), u));
    p1_nxt.eg   = sr_pkg::CW'(sr_pkg::mul_w32(sr_pkg::NW'(cfg.gmax), cfg.eta));
  end

  logic        pv_r [sr_pkg::MAX_EXP];
  sr_pkg::pw_t pd_r [sr_pkg::MAX_EXP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[0] <= 1'b0;
    end else begin
      pv_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    pd_r[0] <= p1_nxt;
  end

  logic [sr_pkg::PEW-1:0] pe;
  assign pe = sr_pkg::clamp_exp(cfg.expo);

  // one multiply by |d| per stage, while the stage index is below the exponent
  for (genvar k = 1; k < sr_pkg::MAX_EXP; k++) begin : g_pow
    sr_pkg::pw_t pk_nxt;

    always_comb begin
      pk_nxt = pd_r[k-1];
      if (k < 32'(pe))
        pk_nxt.pw = sr_pkg::PW'(sr_pkg::mul_w32(sr_pkg::NW'(pd_r[k-1].pw), pd_r[k-1].dm));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[k] <= 1'b0;
      end else begin
        pv_r[k] <= pv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      pd_r[k] <= pk_nxt;
    end
  end

  // gain product and eta coefficients times gmax
  sr_pkg::pw_t pl;
  sr_pkg::nm_t nm_nxt;
  sr_pkg::nm_t nm_r;
  logic        nv_r;

  assign pl = pd_r[sr_pkg::MAX_EXP-1];

  always_comb begin
    nm_nxt.addend = pl.addend;
    nm_nxt.talt   = pl.talt;
    nm_nxt.nl     = pl.nl;
    nm_nxt.gz     = pl.gz;
    nm_nxt.n      = sr_pkg::NW'(sr_pkg::mul_w32(sr_pkg::NW'(pl.pw), pl.lm));
    nm_nxt.wpos   = (nm_nxt.n != '0) && (pl.dneg == pl.lneg);
    nm_nxt.eug    = sr_pkg::CW'(sr_pkg::mul_wg(sr_pkg::NW'(pl.eu), cfg.gmax));
    nm_nxt.eeg    = sr_pkg::CW'(sr_pkg::mul_wg(sr_pkg::NW'(pl.ee), cfg.gmax));
    nm_nxt.ug     = pl.ug;
    nm_nxt.eg     = pl.eg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else begin
      nv_r <= pv_r[sr_pkg::MAX_EXP-1];
    end
  end

  always_ff @(posedge clk) begin
    nm_r <= nm_nxt;
  end

  // dividend coefficient A and divisor B, both scaled by 2^64; the curve is gmax*A/B
  logic [sr_pkg::SHW-1:0] sh;
  logic [sr_pkg::BW-1:0]  nt;
  sr_pkg::stg_t           st_nxt;
  sr_pkg::stg_t           st_r;
  logic                   sv_r;

  always_comb begin
    sh = sr_pkg::SHW'(32'(pe) * sr_pkg::FRAC_BITS);
    nt = sr_pkg::BW'(nm_r.n) << (2 * sr_pkg::EW);
    st_nxt.addend = nm_r.addend;
    st_nxt.talt   = nm_r.talt;
    st_nxt.nl     = nm_r.nl;
    st_nxt.gz     = nm_r.gz;
    st_nxt.r      = '0;
    st_nxt.q      = '0;
    st_nxt.gsh    = cfg.gmax;
    if (cfg.eta == '0) begin
      st_nxt.a = nm_r.wpos ? nt : '0;
      st_nxt.b = (sr_pkg::BW'(cfg.gmax) << (2 * sr_pkg::EW + 32'(sh))) + nt;
    end else if (nm_r.wpos) begin
      st_nxt.a = (sr_pkg::BW'(nm_r.eug) << sh) + nt;
      st_nxt.b = (sr_pkg::BW'(nm_r.ug) << (sr_pkg::EW + 32'(sh))) + nt;
    end else begin
      st_nxt.a = sr_pkg::BW'(nm_r.eeg) << sh;
      st_nxt.b = (sr_pkg::BW'(nm_r.eg) << (sr_pkg::EW + 32'(sh))) + nt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= nv_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign valid_o = sv_r;
  assign item_o  = st_r;

endmodule
`default_nettype wire

>>> rtl/sr_cell.sv
// One step of the gmax-serial division: takes one gmax bit, adds A, removes B up to twice.
// Uses sr_pkg.
`default_nettype none
module sr_cell (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   valid_i,
  input  var  sr_pkg::stg_t item_i,
  output logic        valid_o,
  output sr_pkg::stg_t item_o
);

  logic [sr_pkg::BW+1:0] t;
  logic [sr_pkg::BW+1:0] b1;
  logic [sr_pkg::BW+1:0] b2;
  logic [1:0]            dg;
  sr_pkg::stg_t          item_nxt;
  sr_pkg::stg_t          item_r;
  logic                  valid_r;

  always_comb begin
    t  = {1'b0, item_i.r, 1'b0} + (item_i.gsh[sr_pkg::GW-1] ? {2'b00, item_i.a} : '0);
    b1 = {2'b00, item_i.b};
    b2 = {1'b0, item_i.b, 1'b0};
    item_nxt = item_i;
    if (t >= b2) begin
      dg = 2'd2;
      t  = t - b2;
    end else if (t >= b1) begin
      dg = 2'd1;
      t  = t - b1;
    end else begin
      dg = 2'd0;
    end
    item_nxt.r   = t[sr_pkg::BW-1:0];
    item_nxt.q   = {item_i.q[sr_pkg::GW-2:0], 1'b0} + sr_pkg::GW'(dg);
    item_nxt.gsh = {item_i.gsh[sr_pkg::GW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule
`default_nettype wire

>>> rtl/synaptic_rectifier.sv
// Top level of the synaptic rectifier: configuration registers, front end, division cell
// chain and saturating output stage. Uses sr_pkg, sr_front and sr_cell.
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+-------------------------
//  input   | start, busy, in_sample, in_addend       | start high, busy low
//  result  | out_valid, out_result, out_saturated    | out_valid high (1 cycle)
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_wdata | cfg_valid and cfg_ready
//
// One item per cycle; busy stays low. Each result passes through the input register,
// first stage, power stages, gain product, operand forming, one division cell per gmax
// bit and the output register. Synchronous active-low reset clears all valid flags
// and restores register defaults. Results are shown for one cycle only; the receiver
// cannot stall the pipeline.
`default_nettype none
module synaptic_rectifier (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [sr_pkg::SW-1:0]     in_sample,
  input  wire logic signed [sr_pkg::AW-1:0]     in_addend,
  output logic                                  out_valid,
  output logic signed [sr_pkg::AW-1:0]          out_result,
  output logic                                  out_saturated,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sr_pkg::CIW-1:0]           cfg_index,
  input  wire logic [sr_pkg::CDW-1:0]           cfg_wdata
);

  sr_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= sr_pkg::MODE_RESET;
      cfg_r.gain <= sr_pkg::GAIN_RESET;
      cfg_r.gmax <= sr_pkg::GMAX_RESET;
      cfg_r.eta  <= '0;
      cfg_r.thr  <= '0;
      cfg_r.expo <= sr_pkg::EXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sr_pkg::REG_MODE: cfg_r.mode <= cfg_wdata[1:0];
        sr_pkg::REG_GAIN: cfg_r.gain <= cfg_wdata[31:0];
        sr_pkg::REG_GMAX: cfg_r.gmax <= cfg_wdata[sr_pkg::GW-1:0];
        sr_pkg::REG_ETA:  cfg_r.eta  <= cfg_wdata[sr_pkg::EW-1:0];
        sr_pkg::REG_THR:  cfg_r.thr  <= cfg_wdata[31:0];
        sr_pkg::REG_EXP:  cfg_r.expo <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  logic         cv [sr_pkg::GW+1];
  sr_pkg::stg_t cd [sr_pkg::GW+1];

  sr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start && !busy),
    .in_sample (in_sample),
    .in_addend (in_addend),
    .cfg       (cfg_r),
    .valid_o   (cv[0]),
    .item_o    (cd[0])
  );

  for (genvar i = 0; i < sr_pkg::GW; i++) begin : g_div
    sr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cv[i]),
      .item_i  (cd[i]),
      .valid_o (cv[i+1]),
      .item_o  (cd[i+1])
    );
  end

  sr_pkg::stg_t           fin;
  logic signed [sr_pkg::AW-1:0] tr;
  logic signed [sr_pkg::AW:0]   sum;
  logic                   out_valid_r;
  logic signed [sr_pkg::AW-1:0] out_result_r;
  logic signed [sr_pkg::AW-1:0] out_result_nxt;
  logic                   out_saturated_r;
  logic                   out_saturated_nxt;

  assign fin = cd[sr_pkg::GW];

  always_comb begin
    if (fin.nl)
      tr = fin.gz ? '0 : sr_pkg::AW'(fin.q);
    else
      tr = fin.talt;
    sum = (sr_pkg::AW+1)'(fin.addend) + (sr_pkg::AW+1)'(tr);
    // clip on overflow of the 48-bit range
    if (sum[sr_pkg::AW] != sum[sr_pkg::AW-1]) begin
      out_saturated_nxt = 1'b1;
      out_result_nxt    = sum[sr_pkg::AW] ? {1'b1, {(sr_pkg::AW-1){1'b0}}}
                                          : {1'b0, {(sr_pkg::AW-1){1'b1}}};
    end else begin
      out_saturated_nxt = 1'b0;
      out_result_nxt    = sum[sr_pkg::AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cv[sr_pkg::GW];
    end
  end

  always_ff @(posedge clk) begin
    out_result_r    <= out_result_nxt;
    out_saturated_r <= out_saturated_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_saturated = out_saturated_r;

endmodule
`default_nettype wire

>>> rtl/sr_check.sv
// Port-level checks for synaptic_rectifier, attached by bind.
// Uses sr_pkg for the pipeline latency.
`default_nettype none
module sr_check (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic signed [sr_pkg::AW-1:0] out_result,
  input wire logic                         out_saturated,
  input wire logic                         cfg_ready
);

  // every result comes from an earlier input transfer
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, sr_pkg::LATENCY))
    else $error("result without matching input transfer");

  // every transfer yields a result
  a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(sr_pkg::LATENCY) out_valid)
    else $error("input transfer without result");

  // a clipped result sits at one end of the range
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_result == {1'b0, {(sr_pkg::AW-1){1'b1}}} ||
       out_result == {1'b1, {(sr_pkg::AW-1){1'b0}}}))
    else $error("saturated result not at range limit");

  // the pipeline and config port never hold off
  a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("block stalled");

endmodule

bind synaptic_rectifier sr_check u_sr_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_result    (out_result),
  .out_saturated (out_saturated),
  .cfg_ready     (cfg_ready)
);
`default_nettype wire
